FILE: design/ones_complement_sum_lanes_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ones' complement sum lanes unit
// Immediate-relation and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ONES_COMPLEMENT_SUM_LANES_UNIT_DEFINES_SVH
`define ONES_COMPLEMENT_SUM_LANES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define OCSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante
`define OCSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OCSL_ASSERT_NOW(lbl, ante, cons, msg)
`define OCSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/ocsl_pkg.sv
// ----------------------------------------------------------------------------
// ocsl_pkg
// Shared constants, types and add helpers for the ones' complement sum unit.
// ----------------------------------------------------------------------------
package ocsl_pkg;

  // Beat geometry
  localparam int BEAT_BYTES = 32;
  localparam int LANE_W     = 32;
  localparam int WORD_W     = 64;
  localparam int VB_W       = 6;
  localparam int LANES      = BEAT_BYTES / 4;
  localparam int NUM_WORDS  = BEAT_BYTES / 8;
  localparam int PAIRS      = LANES / 2;
  localparam int BEAT_W     = BEAT_BYTES * 8;

  // Fold pipeline: capture, one stage per lane pair, final carry, one per tail word
  localparam int NSTG = 1 + PAIRS + 1 + NUM_WORDS;

  typedef logic [LANES-1:0][LANE_W-1:0]     lane_vec_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_vec_t;

  // Per-transfer control into every lane
  typedef struct packed {
    logic take;
    logic first;
    logic last;
    logic add;
  } lane_ctl_t;

  // Fold request from the input side
  typedef struct packed {
    logic              load;
    logic              first;
    logic [WORD_W-1:0] initial_sum;
    lane_vec_t         lanes;
    word_vec_t         tail;
  } fold_req_t;

  // Fold pipeline status back to the input side
  typedef struct packed {
    logic adv;
    logic busy;
  } fold_stat_t;

  // One fold pipeline stage
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic              carry;
    lane_vec_t         lanes;
    word_vec_t         tail;
  } fold_stage_t;

  // 32-bit add with end-around carry
  function automatic logic [LANE_W-1:0] add32_eac(input logic [LANE_W-1:0] a,
                                                  input logic [LANE_W-1:0] b);
    logic [LANE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LANE_W-1:0] + {{(LANE_W-1){1'b0}}, s[LANE_W]};
  endfunction

  // 64-bit add with end-around carry
  function automatic logic [WORD_W-1:0] add64_eac(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

  // Keep mask: byte b survives when it lies below the valid-byte count
  function automatic logic [BEAT_BYTES-1:0] byte_keep(input logic [VB_W-1:0] vb);
    logic [BEAT_BYTES-1:0] keep;
    for (int b = 0; b < BEAT_BYTES; b++) begin
      keep[b] = (vb > VB_W'(b));
    end
    return keep;
  endfunction

endpackage

FILE: design/ones_complement_sum_lanes_unit.sv
// ----------------------------------------------------------------------------
// ones_complement_sum_lanes_unit
// Unfolded 64-bit ones' complement sum over 32-byte beats.
// ----------------------------------------------------------------------------
// Usage: send a buffer as beats on the in_ channel (valid/stall). Each beat
// carries four little-endian 64-bit words and a valid-byte count; the first
// beat raises in_first_beat and supplies in_initial_sum, the final beat raises
// in_last_beat. Beats that are not last are taken every cycle, with no stall,
// into eight 32-bit lane accumulators; a first beat that is not last also
// keeps its starting sum for the last beat of its buffer.
// A last beat enters a ten-stage fold pipeline (capture, four lane-pair carry
// steps, final carry, four tail-word adds); its sum appears on out_sum_value
// from the output register behind the last stage, one result per buffer.
// Last beats of back-to-back buffers go in one per cycle unless the receiver
// stalls a result. A last beat without an in_first_beat in its buffer
// continues from the previous result and waits until the fold has drained.
// When the receiver stalls, the result is held in the output register and the
// fold pipeline freezes; data beats still flow, last beats wait.
// Reset (synchronous, active low) clears the lanes, the running sum and all
// pipeline valids; the block is ready in the cycle after reset is released.
// ----------------------------------------------------------------------------
`include "ones_complement_sum_lanes_unit_defines.svh"

module ones_complement_sum_lanes_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_first_beat,
  input  logic [ocsl_pkg::WORD_W-1:0] in_initial_sum,
  input  logic [ocsl_pkg::WORD_W-1:0] in_word0,
  input  logic [ocsl_pkg::WORD_W-1:0] in_word1,
  input  logic [ocsl_pkg::WORD_W-1:0] in_word2,
  input  logic [ocsl_pkg::WORD_W-1:0] in_word3,
  input  logic [ocsl_pkg::VB_W-1:0]   in_valid_bytes,
  input  logic                        in_last_beat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ocsl_pkg::WORD_W-1:0] out_sum_value
);
  import ocsl_pkg::*;

  logic [BEAT_W-1:0]     beat;
  logic [BEAT_W-1:0]     masked;
  logic [BEAT_BYTES-1:0] keep;
  logic                  full;
  logic                  take;
  logic                  pend_vld_r;
  logic [WORD_W-1:0]     pend_init_r;
  lane_ctl_t             lane_ctl;
  lane_vec_t             lane_sum;
  lane_vec_t             lane_acc;
  word_vec_t             tail;
  fold_req_t             req;
  fold_stat_t            stat;

  // Hold a last beat while the fold cannot take it or still owes the running sum
  assign in_stall = in_last_beat &&
                    (!stat.adv || (!in_first_beat && !pend_vld_r && stat.busy));
  assign take     = in_valid && !in_stall;

  // Zero the bytes at and above the valid count
  assign beat = {in_word3, in_word2, in_word1, in_word0};
  assign keep = byte_keep(in_valid_bytes);
  assign full = (in_valid_bytes >= VB_W'(BEAT_BYTES));

  always_comb begin
    for (int b = 0; b < BEAT_BYTES; b++) begin
      masked[8*b +: 8] = keep[b] ? beat[8*b +: 8] : 8'h00;
    end
  end

  // Short last beat goes in as tail words after the fold
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      tail[k] = full ? '0 : masked[WORD_W*k +: WORD_W];
    end
  end

  // Lane control: full beats and all non-last beats go to the lanes
  always_comb begin
    lane_ctl.take  = take;
    lane_ctl.first = in_first_beat;
    lane_ctl.last  = in_last_beat;
    lane_ctl.add   = !in_last_beat || full;
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    ocsl_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .part     (masked[LANE_W*j +: LANE_W]),
      .lane_sum (lane_sum[j]),
      .lane_acc (lane_acc[j])
    );
  end

  // Keep the starting sum of a first beat that is not last; drop it on a last beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      pend_init_r <= '0;
    end else if (take) begin
      if (in_last_beat) begin
        pend_vld_r <= 1'b0;
      end else if (in_first_beat) begin
        pend_vld_r  <= 1'b1;
        pend_init_r <= in_initial_sum;
      end
    end
  end

  // Fold request on a last-beat transfer
  always_comb begin
    req.load        = take && in_last_beat;
    req.first       = in_first_beat || pend_vld_r;
    req.initial_sum = in_first_beat ? in_initial_sum : pend_init_r;
    req.lanes       = lane_sum;
    req.tail        = tail;
  end

  ocsl_fold u_fold (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sum_value (out_sum_value)
  );

  `OCSL_ASSERT_NEXT(a_lane_clear, take && in_last_beat, lane_acc == '0,
                    "lanes not cleared after a last beat")
  `OCSL_ASSERT_NOW(a_data_flow, in_valid && !in_last_beat, !in_stall,
                   "data beat held back")
  `OCSL_ASSERT_NOW(a_stall_last, in_stall, in_last_beat,
                   "stall raised on a data beat")

endmodule

FILE: design/ocsl_lane.sv
// ----------------------------------------------------------------------------
// ocsl_lane
// One 32-bit lane accumulator with end-around carry, cleared on first and last.
// ----------------------------------------------------------------------------
module ocsl_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ocsl_pkg::lane_ctl_t       ctl,
  input  logic [ocsl_pkg::LANE_W-1:0] part,
  output logic [ocsl_pkg::LANE_W-1:0] lane_sum,
  output logic [ocsl_pkg::LANE_W-1:0] lane_acc
);
  import ocsl_pkg::*;

  logic [LANE_W-1:0] acc_r;
  logic [LANE_W-1:0] acc_nxt;
  logic [LANE_W-1:0] base;

  // Start from zero on a first beat, add the part when the beat goes to the lanes
  always_comb begin
    base     = ctl.first ? '0 : acc_r;
    lane_sum = ctl.add ? add32_eac(base, part) : base;
    acc_nxt  = ctl.last ? '0 : lane_sum;
  end

  // Advance on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.take) begin
      acc_r <= acc_nxt;
    end
  end

  assign lane_acc = acc_r;

endmodule

FILE: design/ocsl_fold.sv
// ----------------------------------------------------------------------------
// ocsl_fold
// Merge stage: folds the lane pairs into the running sum through a carry
// chain, adds the final carry, adds the tail words, and registers the result.
// ----------------------------------------------------------------------------
`include "ones_complement_sum_lanes_unit_defines.svh"

module ocsl_fold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ocsl_pkg::fold_req_t         req,
  output ocsl_pkg::fold_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ocsl_pkg::WORD_W-1:0] out_sum_value
);
  import ocsl_pkg::*;

  fold_stage_t       stg_r   [NSTG];
  fold_stage_t       stg_nxt [NSTG];
  logic [NSTG-1:0]   vld_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_sum_value_r;
  logic [WORD_W-1:0] run_sum_r;
  logic              adv;

  // One chain step: add a lane pair plus the carry held from the step before
  function automatic fold_stage_t chain_step(input fold_stage_t p,
                                             input logic [WORD_W-1:0] w);
    fold_stage_t     q;
    logic [WORD_W:0] t;
    q       = p;
    t       = {1'b0, p.acc} + {1'b0, w} + {{WORD_W{1'b0}}, p.carry};
    q.acc   = t[WORD_W-1:0];
    q.carry = t[WORD_W];
    return q;
  endfunction

  // Final carry goes in once, wrapping at 64 bits
  function automatic fold_stage_t carry_step(input fold_stage_t p);
    fold_stage_t q;
    q       = p;
    q.acc   = p.acc + {{(WORD_W-1){1'b0}}, p.carry};
    q.carry = 1'b0;
    return q;
  endfunction

  // Tail word added with end-around carry
  function automatic fold_stage_t tail_step(input fold_stage_t p,
                                            input logic [WORD_W-1:0] w);
    fold_stage_t q;
    q     = p;
    q.acc = add64_eac(p.acc, w);
    return q;
  endfunction

  // Whole pipeline moves unless a result is held by the receiver
  assign adv       = !out_valid_r || !out_stall;
  assign stat.adv  = adv;
  assign stat.busy = |vld_r;

  // Capture: pick the starting sum
  always_comb begin
    stg_nxt[0].acc   = req.first ? req.initial_sum : run_sum_r;
    stg_nxt[0].carry = 1'b0;
    stg_nxt[0].lanes = req.lanes;
    stg_nxt[0].tail  = req.tail;
  end

  // Per-stage next values
  for (genvar s = 1; s < NSTG; s++) begin : g_stg
    if (s <= PAIRS) begin : g_chain
      localparam int K = s - 1;
      assign stg_nxt[s] = chain_step(stg_r[s-1],
                                     {stg_r[s-1].lanes[2*K+1], stg_r[s-1].lanes[2*K]});
    end else if (s == PAIRS + 1) begin : g_carry
      assign stg_nxt[s] = carry_step(stg_r[s-1]);
    end else begin : g_tail
      localparam int T = s - PAIRS - 2;
      assign stg_nxt[s] = tail_step(stg_r[s-1], stg_r[s-1].tail[T]);
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSTG; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
      out_sum_value_r <= stg_r[NSTG-1].acc;
    end
  end

  // Stage valids, output valid and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      run_sum_r   <= '0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], req.load};
      out_valid_r <= vld_r[NSTG-1];
      if (vld_r[NSTG-1]) begin
        run_sum_r <= stg_r[NSTG-1].acc;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sum_value = out_sum_value_r;

  `OCSL_ASSERT_NEXT(a_stage_move, vld_r[0] && adv, vld_r[1], "fold stage lost an entry")
  `OCSL_ASSERT_NEXT(a_sum_track, vld_r[NSTG-1] && adv, run_sum_r == out_sum_value_r,
                    "running sum differs from emitted result")
  `OCSL_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(vld_r[NSTG-1]),
                   "result appeared without a finished fold")

endmodule

FILE: verif/tb_ones_complement_sum_lanes_unit.sv
// ----------------------------------------------------------------------------
// tb_ones_complement_sum_lanes_unit
// Self-checking bench for the 64-bit ones' complement sum over 32-byte beats.
// Beats are sent as whole buffers: a directed set first, then random buffers.
// Random idles on the input side and random stalls on the result side
// exercise the handshakes. A scoreboard keeps its own lane and running-sum
// state, predicts the sum for every last beat, and compares each result in
// order.
// ----------------------------------------------------------------------------
module tb_ones_complement_sum_lanes_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ocsl_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RAND_BEATS   = 550;
  localparam int DRAIN_CYCLES = 24;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                             first;
    word_t                            init_sum;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    logic [VB_W-1:0]                  nbytes;
    logic                             last;
  } beat_t;

  // Scoreboard: mirrors lane and running-sum state, queues predicted sums
  class sum_scoreboard;
    logic [LANES-1:0][LANE_W-1:0] lane_sum;
    word_t                        run_sum;
    word_t                        sums_due[$];
    int                           errors;

    function new();
      lane_sum = '0;
      run_sum  = '0;
      errors   = 0;
    endfunction

    task log_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function logic [LANE_W-1:0] lane_add(logic [LANE_W-1:0] a, logic [LANE_W-1:0] b);
      logic [LANE_W:0] s;
      s = a + b;
      return s[LANE_W-1:0] + s[LANE_W];
    endfunction

    function word_t word_add(word_t a, word_t b);
      logic [WORD_W:0] s;
      s = a + b;
      return s[WORD_W-1:0] + s[WORD_W];
    endfunction

    // Update state for one accepted beat; queue a sum on a last beat
    function void note_beat(beat_t b);
      int unsigned                      n;
      logic [BEAT_W-1:0]                data;
      logic [LANES-1:0][LANE_W-1:0]     parts;
      logic [NUM_WORDS-1:0][WORD_W-1:0] tail;
      logic [WORD_W:0]                  s;
      logic                             cy;
      n = (b.nbytes > BEAT_BYTES) ? BEAT_BYTES : b.nbytes;
      data = b.words;
      // zero the bytes above the valid count
      for (int i = n; i < BEAT_BYTES; i++) begin
        data[8*i +: 8] = '0;
      end
      parts = data;
      tail  = data;
      if (b.first) begin
        run_sum  = b.init_sum;
        lane_sum = '0;
      end
      if (!b.last || n == BEAT_BYTES) begin
        for (int j = 0; j < LANES; j++) begin
          lane_sum[j] = lane_add(lane_sum[j], parts[j]);
        end
      end
      if (!b.last) return;
      // fold lane pairs through one carry chain, then add the final carry
      cy = 1'b0;
      for (int k = 0; k < PAIRS; k++) begin
        s = run_sum + {lane_sum[2*k+1], lane_sum[2*k]} + cy;
        run_sum = s[WORD_W-1:0];
        cy = s[WORD_W];
      end
      run_sum = run_sum + cy;
      // short last beat goes in as padded words
      if (n < BEAT_BYTES) begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          run_sum = word_add(run_sum, tail[k]);
        end
      end
      lane_sum = '0;
      sums_due.push_back(run_sum);
    endfunction

    task check_sum(word_t got);
      word_t want;
      if (sums_due.size() == 0) begin
        log_mismatch($sformatf("unexpected sum_value %h", got));
        return;
      end
      want = sums_due.pop_front();
      if (got !== want) begin
        log_mismatch($sformatf("sum_value %h, expected %h", got, want));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_first_beat;
  logic [WORD_W-1:0]                in_initial_sum;
  logic [WORD_W-1:0]                in_word0;
  logic [WORD_W-1:0]                in_word1;
  logic [WORD_W-1:0]                in_word2;
  logic [WORD_W-1:0]                in_word3;
  logic [VB_W-1:0]                  in_valid_bytes;
  logic                             in_last_beat;
  logic                             out_valid;
  logic                             out_stall;
  logic [WORD_W-1:0]                out_sum_value;

  sum_scoreboard sb = new();
  int unsigned   beats_sent;
  int unsigned   quiet_cycles;

  ones_complement_sum_lanes_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_first_beat  (in_first_beat),
    .in_initial_sum (in_initial_sum),
    .in_word0       (in_word0),
    .in_word1       (in_word1),
    .in_word2       (in_word2),
    .in_word3       (in_word3),
    .in_valid_bytes (in_valid_bytes),
    .in_last_beat   (in_last_beat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sum_value  (out_sum_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly zero, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Bias toward all-ones and all-zero words to stress the carries
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return {32'hFFFF_FFFF, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic beat_t make_beat(bit first, bit last, int unsigned nb);
    beat_t b;
    b.first    = first;
    b.init_sum = rand_word();
    for (int k = 0; k < NUM_WORDS; k++) begin
      b.words[k] = rand_word();
    end
    b.nbytes = VB_W'(nb);
    b.last   = last;
    return b;
  endfunction

  // Present one beat and hold it until the transfer
  task automatic send_beat(beat_t b);
    in_valid       <= 1'b1;
    in_first_beat  <= b.first;
    in_initial_sum <= b.init_sum;
    in_word0       <= b.words[0];
    in_word1       <= b.words[1];
    in_word2       <= b.words[2];
    in_word3       <= b.words[3];
    in_valid_bytes <= b.nbytes;
    in_last_beat   <= b.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
  endtask

  task automatic idle_input(int unsigned n);
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_fixed(bit first, bit last, int unsigned nb, word_t init, word_t fill);
    beat_t b;
    b = make_beat(first, last, nb);
    b.init_sum = init;
    for (int k = 0; k < NUM_WORDS; k++) begin
      b.words[k] = fill;
    end
    send_beat(b);
    idle_input(pick_gap());
  endtask

  task automatic send_random(bit first, bit last, int unsigned nb);
    send_beat(make_beat(first, last, nb));
    idle_input(pick_gap());
  endtask

  // One buffer: mostly well formed, with continuations, restarts and odd counts
  task automatic send_random_buffer();
    int unsigned len;
    int unsigned nb;
    int unsigned r;
    bit          calm;
    bit          first;
    bit          last;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      last  = (i == len - 1);
      first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
      r = $urandom_range(0, 99);
      if (last) begin
        nb = (r < 30) ? BEAT_BYTES : (r < 85) ? $urandom_range(0, BEAT_BYTES - 1)
                                              : $urandom_range(BEAT_BYTES + 1, 63);
      end else begin
        nb = (r < 90) ? BEAT_BYTES : (r < 95) ? $urandom_range(0, BEAT_BYTES - 1)
                                              : $urandom_range(BEAT_BYTES + 1, 63);
      end
      send_beat(make_beat(first, last, nb));
      if (!calm) idle_input(pick_gap());
    end
  endtask

  // Result-side stalls: random bursts with occasional long open stretches
  initial begin
    bit          stalling;
    int unsigned hold;
    out_stall <= 1'b0;
    stalling = 1'b0;
    hold     = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (stalling) begin
        stalling = 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 6);
      end else begin
        hold = pick_gap();
        stalling = (hold != 0);
        if (stalling) hold--;
      end
      out_stall <= stalling;
    end
  end

  // Observe transfers on both channels at the clock edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        sb.note_beat({in_first_beat, in_initial_sum, in_word3, in_word2, in_word1,
                      in_word0, in_valid_bytes, in_last_beat});
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_sum(out_sum_value);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_ones_complement_sum_lanes_unit failed");
      $finish;
    end
  end

  initial begin
    beats_sent     = 0;
    quiet_cycles   = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_first_beat  <= 1'b0;
    in_initial_sum <= '0;
    in_word0       <= '0;
    in_word1       <= '0;
    in_word2       <= '0;
    in_word3       <= '0;
    in_valid_bytes <= '0;
    in_last_beat   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Last beat straight from reset state
    send_fixed(1'b0, 1'b1, BEAT_BYTES, '0, '1);
    // One-beat buffers: all ones, empty, all zero
    send_fixed(1'b1, 1'b1, BEAT_BYTES, '1, '1);
    send_fixed(1'b1, 1'b1, 0, rand_word(), '1);
    send_fixed(1'b1, 1'b1, BEAT_BYTES, '0, '0);
    // Multi-beat all ones to force lane carries, with an oversized count mid-buffer
    send_fixed(1'b1, 1'b0, BEAT_BYTES, '1, '1);
    send_fixed(1'b0, 1'b0, BEAT_BYTES, '1, '1);
    send_fixed(1'b0, 1'b0, 63, '1, '1);
    send_fixed(1'b0, 1'b1, BEAT_BYTES, '1, '1);
    // Short beat that is not last, then a short last beat
    send_random(1'b1, 1'b0, 5);
    send_random(1'b0, 1'b1, 17);
    // Continue from the previous sum
    send_fixed(1'b0, 1'b1, 9, '0, '1);
    // Tail masking at byte boundaries and an oversized last count
    send_fixed(1'b1, 1'b1, 1, rand_word(), '1);
    send_fixed(1'b1, 1'b1, 7, rand_word(), '1);
    send_fixed(1'b1, 1'b1, 8, rand_word(), '1);
    send_fixed(1'b1, 1'b1, 31, rand_word(), '1);
    send_fixed(1'b1, 1'b1, 33, rand_word(), '1);
    // Restart in the middle of a buffer
    send_random(1'b1, 1'b0, BEAT_BYTES);
    send_random(1'b1, 1'b1, 24);
    send_random(1'b1, 1'b0, BEAT_BYTES);
    send_random(1'b0, 1'b1, 0);

    beats_sent = 0;
    while (beats_sent < RAND_BEATS) begin
      send_random_buffer();
    end
    in_valid <= 1'b0;

    // Drain outstanding sums, then let the pipeline settle
    while (sb.sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_ones_complement_sum_lanes_unit passed");
    end else begin
      $display("tb_ones_complement_sum_lanes_unit failed");
    end
    $finish;
  end

endmodule
